// ===== rtl/core/ptd_pkg.sv =====
// Shared constants, types and microcode for the periodic task dispatcher.
package ptd_pkg;

    // Slot organization.
    localparam int TASK_SLOTS = 8;
    localparam int NSLOTS     = TASK_SLOTS + 1;
    localparam int IDX_W      = 4;
    localparam int TICK_W     = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_SETINT = 3'd3;
    localparam logic [OP_W-1:0] OP_IDLE   = 3'd4;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;

    // Microcode addresses.
    localparam int UA_W = 4;
    typedef logic [UA_W-1:0] t_uaddr;
    localparam t_uaddr UA_FETCH     = 4'd0;
    localparam t_uaddr UA_TICK      = 4'd1;
    localparam t_uaddr UA_CREATE    = 4'd2;
    localparam t_uaddr UA_DELETE    = 4'd3;
    localparam t_uaddr UA_SETINT    = 4'd4;
    localparam t_uaddr UA_IDLE      = 4'd5;
    localparam t_uaddr UA_SCAN_EVAL = 4'd6;
    localparam t_uaddr UA_SCAN_END  = 4'd7;
    localparam t_uaddr UA_NOP       = 4'd8;

    // Datapath action selected by a control word.
    typedef enum logic [3:0] {
        A_NONE   = 4'd0,
        A_FETCH  = 4'd1,
        A_TICK   = 4'd2,
        A_CREATE = 4'd3,
        A_DELETE = 4'd4,
        A_SETINT = 4'd5,
        A_IDLE   = 4'd6,
        A_SCAN   = 4'd7,
        A_FLUSH  = 4'd8,
        A_NOP    = 4'd9
    } t_act;

    // How the step counter advances.
    typedef enum logic [1:0] {
        J_GOTO  = 2'd0,
        J_OPDEC = 2'd1,
        J_LOOP  = 2'd2
    } t_jmp;

    typedef struct packed {
        t_act   act;
        t_jmp   jmp;
        t_uaddr target;
    } t_uword;

    // One slot as seen on the table read port.
    typedef struct packed {
        logic              active;
        logic              pz;
        logic [TICK_W-1:0] pm1;
        logic [TICK_W-1:0] last_run;
    } t_slot_entry;

    // One write request to the slot table.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              set_act;
        logic              clr_act;
        logic              wr_per;
        logic              pz;
        logic [TICK_W-1:0] pm1;
        logic              wr_last;
        logic [TICK_W-1:0] last_run;
    } t_slot_wr;

    // Control store. J_LOOP stays on the target until the last slot has been
    // visited and then falls through to the next address.
    function automatic t_uword ucode_rom(input t_uaddr addr);
        t_uword w;
        case (addr)
            UA_FETCH:     w = '{act: A_FETCH,  jmp: J_OPDEC, target: UA_FETCH};
            UA_TICK:      w = '{act: A_TICK,   jmp: J_GOTO,  target: UA_FETCH};
            UA_CREATE:    w = '{act: A_CREATE, jmp: J_GOTO,  target: UA_FETCH};
            UA_DELETE:    w = '{act: A_DELETE, jmp: J_GOTO,  target: UA_FETCH};
            UA_SETINT:    w = '{act: A_SETINT, jmp: J_GOTO,  target: UA_FETCH};
            UA_IDLE:      w = '{act: A_IDLE,   jmp: J_GOTO,  target: UA_FETCH};
            UA_SCAN_EVAL: w = '{act: A_SCAN,   jmp: J_LOOP,  target: UA_SCAN_EVAL};
            UA_SCAN_END:  w = '{act: A_FLUSH,  jmp: J_GOTO,  target: UA_FETCH};
            UA_NOP:       w = '{act: A_NOP,    jmp: J_GOTO,  target: UA_FETCH};
            default:      w = '{act: A_NONE,   jmp: J_GOTO,  target: UA_FETCH};
        endcase
        return w;
    endfunction

    // Entry point of the routine for each operation code.
    function automatic t_uaddr op_entry(input logic [OP_W-1:0] op);
        t_uaddr a;
        case (op)
            OP_TICK:   a = UA_TICK;
            OP_CREATE: a = UA_CREATE;
            OP_DELETE: a = UA_DELETE;
            OP_SETINT: a = UA_SETINT;
            OP_IDLE:   a = UA_IDLE;
            OP_SCAN:   a = UA_SCAN_EVAL;
            default:   a = UA_NOP;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/ptd_sequencer.sv =====
// Microcode step counter and control store of the periodic task dispatcher.
module ptd_sequencer
    import ptd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  logic            i_loop_end,
    output t_uword          o_uword,
    output logic            o_busy
);

    t_uaddr r_upc;
    t_uaddr n_upc;
    t_uword uw;

    assign uw      = ucode_rom(r_upc);
    assign o_uword = uw;
    assign o_busy  = (r_upc != UA_FETCH);

    always_comb begin
        case (uw.jmp)
            J_OPDEC: n_upc = i_start ? op_entry(i_op) : r_upc;
            J_LOOP:  n_upc = i_loop_end ? UA_W'(r_upc + 1'b1) : uw.target;
            default: n_upc = uw.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== rtl/core/ptd_slot_table.sv =====
// Slot table: active flags, stored intervals and last-run stamps.
module ptd_slot_table
    import ptd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_slot_entry      o_rd,
    input  t_slot_wr         i_wr
);

    logic [NSLOTS-1:0] r_active;
    logic              r_pz   [NSLOTS];
    logic [TICK_W-1:0] r_pm1  [NSLOTS];
    logic [TICK_W-1:0] r_last [NSLOTS];
    logic              rd_ok;

    // Indexes past the idle slot read as an empty, inactive slot.
    assign rd_ok = ({1'b0, i_rd_idx} < (IDX_W + 1)'(NSLOTS));

    always_comb begin
        o_rd = '0;
        if (rd_ok) begin
            o_rd.active   = r_active[i_rd_idx];
            o_rd.pz       = r_pz[i_rd_idx];
            o_rd.pm1      = r_pm1[i_rd_idx];
            o_rd.last_run = r_last[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            if (i_wr.set_act) begin
                r_active[i_wr.idx] <= 1'b1;
            end
            if (i_wr.clr_act) begin
                r_active[i_wr.idx] <= 1'b0;
            end
        end
    end

    // A create writes interval and stamp along with the active flag; idle writes only the interval.
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_per) begin
            r_pz[i_wr.idx]  <= i_wr.pz;
            r_pm1[i_wr.idx] <= i_wr.pm1;
        end
        if (i_wr.wr_last) begin
            r_last[i_wr.idx] <= i_wr.last_run;
        end
    end

endmodule

// ===== rtl/core/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: microcoded scheduler datapath.
//
//  Channel   | Ports                                          | Handshake
//  ----------+------------------------------------------------+---------------------------
//  command   | i_op, i_slot, i_period                         | start high, busy low
//  result    | o_status, o_dispatch_valid, o_task_index, o_last| o_result_valid, one cycle
//
// A non-scan operation runs the accept step and then one execute step.
// A scan runs the accept step, the slot-visit loop of the microprogram,
// which reads one slot table entry per cycle, and a closing flush step.
// The synchronous active-low reset clears the step counter, the tick counter,
// the active flags and the result strobe; stored intervals need no reset.
// Results are strobed for exactly one cycle; the receiver cannot stall them.
module periodic_task_dispatcher
    import ptd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [IDX_W-1:0]    i_slot,
    input  logic [TICK_W-1:0]   i_period,
    output logic                o_result_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_dispatch_valid,
    output logic [IDX_W-1:0]    o_task_index,
    output logic                o_last
);

    t_uword uw;
    logic   seq_busy;
    logic   loop_end;

    // Transaction fields held for the duration of the routine. The interval
    // is kept as period minus one plus a zero flag, so the due test needs
    // only one subtract and one compare.
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic                r_pz, n_pz;
    logic [TICK_W-1:0]   r_pm1, n_pm1;

    // Scan index and the one held-back dispatch. A dispatch is only known to
    // be the final one when the scan ends, so each is released one find late.
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;

    logic                r_vld, n_vld;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_dv, n_dv;
    logic [IDX_W-1:0]    r_tidx, n_tidx;
    logic                r_last, n_last;

    logic [IDX_W-1:0]    rd_idx;
    t_slot_entry         rd;
    t_slot_wr            wr;
    logic                in_range;
    logic [TICK_W-1:0]   elapsed;
    logic                due;

    ptd_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_op       (i_op),
        .i_loop_end (loop_end),
        .o_uword    (uw),
        .o_busy     (seq_busy)
    );

    ptd_slot_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .o_rd     (rd),
        .i_wr     (wr)
    );

    assign busy     = seq_busy;
    assign loop_end = (r_idx == IDX_W'(NSLOTS - 1));
    assign rd_idx   = (uw.act == A_SCAN) ? r_idx : r_slot;
    assign in_range = (r_slot < IDX_W'(TASK_SLOTS));

    // Elapsed time wraps modulo 2^32 like the tick counter itself.
    assign elapsed  = r_tick - rd.last_run;
    assign due      = rd.active && (rd.pz || (elapsed >= rd.pm1));

    always_comb begin
        n_tick     = r_tick;
        n_slot     = r_slot;
        n_pz       = r_pz;
        n_pm1      = r_pm1;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_vld      = 1'b0;
        n_status   = ST_OK;
        n_dv       = 1'b0;
        n_tidx     = '0;
        n_last     = 1'b1;
        wr         = '0;
        wr.idx     = r_slot;
        wr.pz      = r_pz;
        wr.pm1     = r_pm1;

        case (uw.act)
            A_FETCH: begin
                if (start) begin
                    n_slot = i_slot;
                    n_pz   = (i_period == '0);
                    n_pm1  = i_period - 1'b1;
                    n_idx  = '0;
                    n_pend = 1'b0;
                end
            end
            A_TICK: begin
                n_tick = r_tick + 1'b1;
                n_vld  = 1'b1;
            end
            A_CREATE: begin
                n_vld = 1'b1;
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else if (rd.active) begin
                    n_status = ST_BUSY;
                end else begin
                    wr.set_act  = 1'b1;
                    wr.wr_per   = 1'b1;
                    wr.wr_last  = 1'b1;
                    wr.last_run = '0;
                end
            end
            A_DELETE: begin
                n_vld      = 1'b1;
                wr.clr_act = in_range;
            end
            A_SETINT: begin
                n_vld     = 1'b1;
                wr.wr_per = in_range;
            end
            A_IDLE: begin
                // The idle slot always runs, so its interval becomes zero.
                n_vld      = 1'b1;
                wr.idx     = IDX_W'(TASK_SLOTS);
                wr.set_act = 1'b1;
                wr.wr_per  = 1'b1;
                wr.pz      = 1'b1;
                wr.pm1     = '1;
            end
            A_SCAN: begin
                if (due) begin
                    wr.idx      = r_idx;
                    wr.wr_last  = 1'b1;
                    wr.last_run = r_tick;
                    if (r_pend) begin
                        n_vld  = 1'b1;
                        n_dv   = 1'b1;
                        n_tidx = r_pend_idx;
                        n_last = 1'b0;
                    end
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                end
                if (!loop_end) begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            A_FLUSH: begin
                // Release the held dispatch as the final one, or report that
                // nothing was due.
                n_vld  = 1'b1;
                n_pend = 1'b0;
                if (r_pend) begin
                    n_dv   = 1'b1;
                    n_tidx = r_pend_idx;
                end
            end
            A_NOP: begin
                n_vld = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_pend <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_tick <= n_tick;
            r_pend <= n_pend;
            r_vld  <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_pz       <= n_pz;
        r_pm1      <= n_pm1;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_dv       <= n_dv;
        r_tidx     <= n_tidx;
        r_last     <= n_last;
    end

    assign o_result_valid   = r_vld;
    assign o_status         = r_status;
    assign o_dispatch_valid = r_dv;
    assign o_task_index     = r_tidx;
    assign o_last           = r_last;

endmodule

// ===== tb/periodic_task_dispatcher_tb.sv =====
// Self-checking testbench for the periodic task dispatcher, with its own scheduler model.
`timescale 1ns / 1ps

module periodic_task_dispatcher_tb;
    import ptd_pkg::*;

    // Op codes 6 and 7 are not assigned; the block must answer them as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    // A scan is the longest command, and the drain is sized from its length,
    // which is plenty to catch a stray strobe.
    localparam int DRAIN_CYCLES = 2 * (NSLOTS + 2);

    // Slowest correct run: about 150 commands, each with its busy time plus a
    // sender gap, plus drains; the limit leaves a wide margin over that.
    localparam int unsigned CYCLE_LIMIT = 60000;

    localparam int RANDOM_HALF = 57;

    // One result transaction as it appears on the result ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                dispatch_valid;
        logic [IDX_W-1:0]    task_index;
        logic                last;
    } t_dispatch_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op = OP_TICK;
    logic [IDX_W-1:0]    i_slot = '0;
    logic [TICK_W-1:0]   i_period = '0;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_dispatch_valid;
    logic [IDX_W-1:0]    o_task_index;
    logic                o_last;

    // The scheduler state as the testbench believes it to be.
    logic [TICK_W-1:0]   sched_tick;
    logic [TICK_W-1:0]   sched_period   [NSLOTS];
    logic [TICK_W-1:0]   sched_last_run [NSLOTS];
    logic                sched_active   [NSLOTS];

    // Results still owed by the block, oldest first.
    t_dispatch_result    expected_results[$];
    t_dispatch_result    want_result;

    int                  error_count = 0;
    int                  commands_sent = 0;
    int                  results_checked = 0;
    int                  dispatches_seen = 0;
    int unsigned         cycle_count = 0;

    periodic_task_dispatcher dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_slot           (i_slot),
        .i_period         (i_period),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_dispatch_valid (o_dispatch_valid),
        .o_task_index     (o_task_index),
        .o_last           (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Works out the results of one accepted command and updates the model
    // state. A scan walks slot 0 up to the idle slot, which is also the
    // priority order, so results land in the queue in the order they come out.
    task automatic predict_results(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] slot,
                                   input logic [TICK_W-1:0] period);
        t_dispatch_result r;
        logic             in_range;
        logic [TICK_W-1:0] elapsed;
        int               n;
        in_range = slot < TASK_SLOTS;
        r = '{ST_OK, 1'b0, '0, 1'b1};
        if (op == OP_SCAN) begin
            n = 0;
            for (int i = 0; i < NSLOTS; i++) begin
                if (sched_active[i]) begin
                    // The elapsed time wraps modulo 2^32, and so does period - 1,
                    // which is why a zero period is tested on its own.
                    elapsed = sched_tick - sched_last_run[i];
                    if (sched_period[i] == '0 || elapsed >= sched_period[i] - 32'd1) begin
                        sched_last_run[i] = sched_tick;
                        expected_results.push_back('{ST_OK, 1'b1, IDX_W'(i), 1'b0});
                        n++;
                    end
                end
            end
            if (n == 0) begin
                // Nothing due: a single empty result closes the scan.
                expected_results.push_back(r);
            end else begin
                expected_results[expected_results.size() - 1].last = 1'b1;
            end
        end else begin
            case (op)
                OP_TICK: begin
                    sched_tick = sched_tick + 32'd1;
                end
                OP_CREATE: begin
                    if (!in_range) begin
                        r.status = ST_RANGE;
                    end else if (sched_active[slot]) begin
                        r.status = ST_BUSY;
                    end else begin
                        sched_period[slot]   = period;
                        sched_last_run[slot] = '0;
                        sched_active[slot]   = 1'b1;
                    end
                end
                OP_DELETE: begin
                    // Out-of-range slots, including the idle slot, are left alone.
                    if (in_range) sched_active[slot] = 1'b0;
                end
                OP_SETINT: begin
                    // The interval is stored even when the slot is not active.
                    if (in_range) sched_period[slot] = period;
                end
                OP_IDLE: begin
                    sched_active[TASK_SLOTS] = 1'b1;
                    sched_period[TASK_SLOTS] = '0;
                end
                default: begin
                end
            endcase
            expected_results.push_back(r);
        end
    endtask

    // Drives one command and holds it until the block takes it. Start stays
    // high afterwards for back-to-back commands; whoever pauses next lowers it.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] slot,
                                input logic [TICK_W-1:0] period);
        start    <= 1'b1;
        i_op     <= op;
        i_slot   <= slot;
        i_period <= period;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_results(op, slot, period);
        commands_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Every result transaction is compared with the oldest expectation, one
    // field at a time. The receiver cannot stall, so this samples every edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (index %0d, valid %0b)",
                                          o_task_index, o_dispatch_valid));
            end else begin
                want_result = expected_results.pop_front();
                if (o_status !== want_result.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want_result.status));
                if (o_dispatch_valid !== want_result.dispatch_valid)
                    report_mismatch($sformatf("dispatch_valid %0b, expected %0b",
                                              o_dispatch_valid, want_result.dispatch_valid));
                if (o_task_index !== want_result.task_index)
                    report_mismatch($sformatf("task_index %0d, expected %0d",
                                              o_task_index, want_result.task_index));
                if (o_last !== want_result.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              o_last, want_result.last));
                results_checked++;
                if (want_result.dispatch_valid) dispatches_seen++;
            end
        end
    end

    // A scan straight after reset has nothing to dispatch.
    task automatic test_empty_scan();
        send_command(OP_SCAN, 4'd0, '0);
    endtask

    // Creates at both ends of the period range, then the two rejections:
    // slots past the table and a slot that is already taken.
    task automatic test_create_and_reject();
        send_command(OP_CREATE, 4'd0, '0);
        send_command(OP_CREATE, IDX_W'(TASK_SLOTS - 1), '1);
        send_command(OP_CREATE, IDX_W'(TASK_SLOTS), 32'h5A5A_A5A5);
        send_command(OP_CREATE, 4'd15, 32'd3);
        send_command(OP_CREATE, 4'd0, 32'd9);
    endtask

    // Zero period fires every scan, an all-ones period never does in this run,
    // and a period of one is due at once. Setting the interval of an empty
    // slot still stores it, and a create then overwrites it.
    task automatic test_interval_and_scan();
        send_command(OP_SCAN, 4'd0, '0);
        send_command(OP_TICK, 4'd0, '0);
        idle_gap(3);
        send_command(OP_TICK, 4'd0, '0);
        send_command(OP_SCAN, 4'd0, '0);
        send_command(OP_SETINT, IDX_W'(TASK_SLOTS - 1), 32'd1);
        send_command(OP_SETINT, 4'd12, 32'd7);
        send_command(OP_SETINT, 4'd3, 32'd5);
        send_command(OP_CREATE, 4'd3, 32'd2);
        send_command(OP_SCAN, 4'd0, '0);
    endtask

    // Registering the idle task makes the spare slot run on every scan, last.
    task automatic test_idle_slot();
        send_command(OP_IDLE, 4'd0, '0);
        send_command(OP_SCAN, 4'd0, '0);
        send_command(OP_TICK, 4'd0, '0);
        send_command(OP_SCAN, 4'd0, '0);
    endtask

    // Deleting a task slot stops its dispatches; deletes of slots past the
    // idle slot change nothing.
    task automatic test_delete();
        send_command(OP_DELETE, 4'd0, '0);
        send_command(OP_DELETE, IDX_W'(TASK_SLOTS + 1), '0);
        send_command(OP_DELETE, 4'd15, '1);
        send_command(OP_SCAN, 4'd0, '0);
    endtask

    task automatic test_unused_ops();
        send_command(OP_SPARE6, 4'd5, 32'hFFFF_0000);
        send_command(OP_SPARE7, 4'd10, 32'h0000_FFFF);
    endtask

    // Bursts of random commands with random gaps. Ticks and scans dominate so
    // that created tasks actually come due; periods are mostly short for the
    // same reason, with the occasional full-width value. Spare op codes and
    // deletes or interval writes past the table do not count toward the total.
    task automatic test_random_traffic(input int item_target);
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  slot;
        logic [TICK_W-1:0] period;
        int                counted;
        int                burst_left;
        int                pick;
        counted = 0;
        while (counted < item_target) begin
            burst_left = $urandom_range(1, 12);
            while (burst_left > 0 && counted < item_target) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)      op = OP_TICK;
                else if (pick < 55) op = OP_SCAN;
                else if (pick < 70) op = OP_CREATE;
                else if (pick < 78) op = OP_DELETE;
                else if (pick < 88) op = OP_SETINT;
                else if (pick < 93) op = OP_IDLE;
                else                op = $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
                if ($urandom_range(0, 99) < 85)
                    slot = IDX_W'($urandom_range(0, TASK_SLOTS - 1));
                else
                    slot = IDX_W'($urandom_range(0, 15));
                pick = $urandom_range(0, 19);
                if (pick < 14)      period = $urandom_range(0, 6);
                else if (pick < 17) period = $urandom_range(7, 40);
                else                period = $urandom();
                send_command(op, slot, period);
                if (op != OP_SPARE6 && op != OP_SPARE7 &&
                    !((op == OP_DELETE || op == OP_SETINT) && slot >= TASK_SLOTS))
                    counted++;
                burst_left--;
            end
            // Gaps of random length land on every step of a scan; some bursts run
            // straight into the next one.
            pick = $urandom_range(0, 9);
            if (pick == 0)     wait_for_drain();
            else if (pick < 4) begin
            end
            else               idle_gap($urandom_range(1, 12));
        end
    endtask

    initial begin
        sched_tick = '0;
        for (int i = 0; i < NSLOTS; i++) begin
            sched_period[i]   = '0;
            sched_last_run[i] = '0;
            sched_active[i]   = 1'b0;
        end
        sched_period[TASK_SLOTS] = '1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_scan();
        test_create_and_reject();
        test_interval_and_scan();
        test_idle_slot();
        test_delete();
        test_unused_ops();
        test_random_traffic(RANDOM_HALF);
        // Let the block run completely dry once before the second half.
        wait_for_drain();
        test_random_traffic(RANDOM_HALF);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands and %0d results, %0d of them task dispatches.",
                 commands_sent, results_checked, dispatches_seen);
        $display("Directed cases: rejects, interval edits, idle slot, deletes, spare op codes.");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
